### rtl/bsc_pkg.sv
// Shared types, widths and codes for the banker's safety check block.
`timescale 1ns / 1ps

package bsc_pkg;

  // Default sizing of the tables.
  localparam int unsigned DEF_MAX_PROCS     = 8;
  localparam int unsigned DEF_MAX_RESOURCES = 4;
  localparam int unsigned DEF_COUNT_BITS    = 8;

  // Fixed field widths of the beats.
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned PROC_IDX_W  = 3;
  localparam int unsigned RES_IDX_W   = 2;
  localparam int unsigned AMOUNT_W    = 8;
  localparam int unsigned PROC_ID_W   = 3;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 4;
  localparam int unsigned PROCS_CFG_W = 4;
  localparam int unsigned RES_CFG_W   = 3;

  localparam logic [CFG_IDX_W-1:0]   CFG_PROCS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0]   CFG_RES     = 2'd1;
  localparam logic [PROCS_CFG_W-1:0] PROCS_RESET = 4'd8;
  localparam logic [RES_CFG_W-1:0]   RES_RESET   = 3'd4;

  // Input beat kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_ALLOC = 2'd0,
    KIND_LOAD_MAX   = 2'd1,
    KIND_LOAD_AVAIL = 2'd2,
    KIND_RUN        = 2'd3
  } kind_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEEK,
    S_READ,
    S_CMP,
    S_DECIDE,
    S_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init;
    logic new_pass;
    logic next_p;
    logic start_proc;
    logic compare;
    logic accept;
    logic finish;
  } bsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic p_end;
    logic p_done;
    logic r_last;
    logic fits;
    logic all_done;
    logic progress;
    logic has_pending;
    logic out_free;
  } bsc_status_t;

endpackage

### rtl/bsc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/bsc_ctrl.sv
// Controller state machine that sequences loads and the safety scan.
`timescale 1ns / 1ps

module bsc_ctrl import bsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  kind_e       in_kind_i,
  output logic        in_ready_o,
  input  bsc_status_t status_i,
  output bsc_cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == KIND_RUN) begin
            cmd_o.init = 1'b1;
            state_d    = S_SEEK;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_SEEK: begin
        if (status_i.p_end) begin
          if (status_i.all_done || !status_i.progress) begin
            state_d = S_FINISH;
          end else begin
            cmd_o.new_pass = 1'b1;
          end
        end else if (status_i.p_done) begin
          cmd_o.next_p = 1'b1;
        end else begin
          cmd_o.start_proc = 1'b1;
          state_d          = S_READ;
        end
      end
      S_READ: begin
        // Table read for the current resource is in flight.
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = status_i.r_last ? S_DECIDE : S_READ;
      end
      S_DECIDE: begin
        if (!status_i.fits) begin
          cmd_o.next_p = 1'b1;
          state_d      = S_SEEK;
        end else if (!status_i.has_pending || status_i.out_free) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SEEK;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/bsc_datapath.sv
// Datapath: configuration, tables, work vector, scan counters and result register.
`timescale 1ns / 1ps

module bsc_datapath import bsc_pkg::*; #(
  parameter int unsigned MAX_PROCS     = DEF_MAX_PROCS,
  parameter int unsigned MAX_RESOURCES = DEF_MAX_RESOURCES,
  parameter int unsigned COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  kind_e                 in_kind_i,
  input  logic [PROC_IDX_W-1:0] in_proc_i,
  input  logic [RES_IDX_W-1:0]  in_res_i,
  input  logic [AMOUNT_W-1:0]   in_amount_i,
  input  bsc_cmd_t              cmd_i,
  output bsc_status_t           status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PROC_ID_W-1:0]  out_proc_id_o,
  output logic                  out_has_proc_o,
  output logic                  out_safe_o,
  output logic                  out_last_o
);

  localparam int unsigned PCNT_W = $clog2(MAX_PROCS + 1);
  localparam int unsigned PIDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned RCNT_W = $clog2(MAX_RESOURCES + 1);
  localparam int unsigned RIDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int unsigned DEPTH  = MAX_PROCS * MAX_RESOURCES;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WORK_W = COUNT_BITS + PCNT_W;

  logic [PROCS_CFG_W-1:0] procs_q;
  logic [RES_CFG_W-1:0]   res_q;
  logic [PCNT_W-1:0]      np;
  logic [RCNT_W-1:0]      nr;

  logic [COUNT_BITS-1:0]  amt;
  logic                   ld_ok;
  logic                   alloc_we, max_we, avail_we;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [COUNT_BITS-1:0]  a_rd, m_rd, a_val, m_val;
  logic [DEPTH-1:0]       alloc_vld_q, max_vld_q;
  logic                   a_vld_q, m_vld_q;

  logic [COUNT_BITS-1:0]  avail_q [MAX_RESOURCES];
  logic [WORK_W-1:0]      work_q  [MAX_RESOURCES];
  logic [COUNT_BITS-1:0]  abuf_q  [MAX_RESOURCES];
  logic [MAX_PROCS-1:0]   finished_q;
  logic [PCNT_W-1:0]      done_q, p_q;
  logic [PIDX_W-1:0]      p_idx;
  logic [RIDX_W-1:0]      r_q;
  logic                   fits_q, progress_q;
  logic                   pend_valid_q;
  logic [PROC_ID_W-1:0]   pend_id_q;
  logic [WORK_W:0]        sum;
  logic                   no_fit;
  logic                   all_done, out_free, push;

  logic                   out_valid_q;
  logic [PROC_ID_W-1:0]   out_id_q;
  logic                   out_has_q, out_safe_q, out_last_q;

  // Configuration registers; the user writes them only when idle; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      procs_q <= PROCS_RESET;
      res_q   <= RES_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PROCS: procs_q <= cfg_data_i[PROCS_CFG_W-1:0];
        CFG_RES:   res_q   <= cfg_data_i[RES_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Counts in use, saturated to one and to the table size.
  always_comb begin
    if (procs_q == '0) begin
      np = PCNT_W'(1);
    end else if (int'(procs_q) > MAX_PROCS) begin
      np = PCNT_W'(MAX_PROCS);
    end else begin
      np = PCNT_W'(procs_q);
    end
    if (res_q == '0) begin
      nr = RCNT_W'(1);
    end else if (int'(res_q) > MAX_RESOURCES) begin
      nr = RCNT_W'(MAX_RESOURCES);
    end else begin
      nr = RCNT_W'(res_q);
    end
  end

  // Load decode; entries outside the tables are dropped.
  assign amt      = COUNT_BITS'(in_amount_i);
  assign ld_ok    = (int'(in_proc_i) < MAX_PROCS) && (int'(in_res_i) < MAX_RESOURCES);
  assign alloc_we = cmd_i.load && (in_kind_i == KIND_LOAD_ALLOC) && ld_ok;
  assign max_we   = cmd_i.load && (in_kind_i == KIND_LOAD_MAX) && ld_ok;
  assign avail_we = cmd_i.load && (in_kind_i == KIND_LOAD_AVAIL) &&
                    (int'(in_res_i) < MAX_RESOURCES);
  assign wr_addr  = AW'(int'(in_proc_i) * MAX_RESOURCES + int'(in_res_i));

  // Scan address of the current process and resource.
  assign p_idx   = p_q[PIDX_W-1:0];
  assign rd_addr = AW'(int'(p_idx) * MAX_RESOURCES + int'(r_q));

  bsc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_alloc_ram (
    .clk_i     (clk_i),
    .wr_en_i   (alloc_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (amt),
    .rd_addr_i (rd_addr),
    .rd_data_o (a_rd)
  );

  bsc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_max_ram (
    .clk_i     (clk_i),
    .wr_en_i   (max_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (amt),
    .rd_addr_i (rd_addr),
    .rd_data_o (m_rd)
  );

  // Written marks; an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_vld_q <= '0;
      max_vld_q   <= '0;
      a_vld_q     <= 1'b0;
      m_vld_q     <= 1'b0;
    end else begin
      if (alloc_we) begin
        alloc_vld_q[wr_addr] <= 1'b1;
      end
      if (max_we) begin
        max_vld_q[wr_addr] <= 1'b1;
      end
      a_vld_q <= alloc_vld_q[rd_addr];
      m_vld_q <= max_vld_q[rd_addr];
    end
  end

  assign a_val = a_vld_q ? a_rd : '0;
  assign m_val = m_vld_q ? m_rd : '0;

  // Need fits when max <= work + alloc for this resource.
  assign sum    = (WORK_W + 1)'(work_q[r_q]) + (WORK_W + 1)'(a_val);
  assign no_fit = (WORK_W + 1)'(m_val) > sum;

  assign all_done = (done_q == np);
  assign out_free = !out_valid_q || out_ready_i;
  assign push     = (cmd_i.accept && pend_valid_q) || cmd_i.finish;

  // Available vector, work vector and scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_RESOURCES; i++) begin
        avail_q[i] <= '0;
        work_q[i]  <= '0;
      end
      finished_q   <= '0;
      done_q       <= '0;
      p_q          <= '0;
      r_q          <= '0;
      fits_q       <= 1'b0;
      progress_q   <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (avail_we) begin
        avail_q[RIDX_W'(in_res_i)] <= amt;
      end
      if (cmd_i.init) begin
        for (int i = 0; i < MAX_RESOURCES; i++) begin
          work_q[i] <= WORK_W'(avail_q[i]);
        end
        finished_q   <= '0;
        done_q       <= '0;
        p_q          <= '0;
        progress_q   <= 1'b0;
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.new_pass) begin
        p_q        <= '0;
        progress_q <= 1'b0;
      end
      if (cmd_i.next_p) begin
        p_q <= p_q + 1'b1;
      end
      if (cmd_i.start_proc) begin
        r_q    <= '0;
        fits_q <= 1'b1;
      end
      if (cmd_i.compare) begin
        r_q <= r_q + 1'b1;
        if (no_fit) begin
          fits_q <= 1'b0;
        end
      end
      if (cmd_i.accept) begin
        for (int i = 0; i < MAX_RESOURCES; i++) begin
          if (i < int'(nr)) begin
            work_q[i] <= work_q[i] + WORK_W'(abuf_q[i]);
          end
        end
        finished_q[p_idx] <= 1'b1;
        done_q            <= done_q + 1'b1;
        progress_q        <= 1'b1;
        pend_valid_q      <= 1'b1;
        p_q               <= p_q + 1'b1;
      end
    end
  end

  // Allocation row of the process under test, kept for the work update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      abuf_q[r_q] <= a_val;
    end
    if (cmd_i.accept) begin
      pend_id_q <= PROC_ID_W'(p_q);
    end
  end

  // Result register; the newest accepted process is held back until the
  // next one shows whether it was the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_id_q   <= pend_valid_q ? pend_id_q : '0;
      out_has_q  <= pend_valid_q;
      out_safe_q <= pend_valid_q && all_done;
      out_last_q <= 1'b1;
    end else if (cmd_i.accept && pend_valid_q) begin
      out_id_q   <= pend_id_q;
      out_has_q  <= 1'b1;
      out_safe_q <= 1'b0;
      out_last_q <= 1'b0;
    end
  end

  assign status_o.p_end       = (p_q == np);
  assign status_o.p_done      = finished_q[p_idx];
  assign status_o.r_last      = (RCNT_W'(r_q) == (nr - RCNT_W'(1)));
  assign status_o.fits        = fits_q;
  assign status_o.all_done    = all_done;
  assign status_o.progress    = progress_q;
  assign status_o.has_pending = pend_valid_q;
  assign status_o.out_free    = out_free;

  assign out_valid_o    = out_valid_q;
  assign out_proc_id_o  = out_id_q;
  assign out_has_proc_o = out_has_q;
  assign out_safe_o     = out_safe_q;
  assign out_last_o     = out_last_q;

endmodule

### rtl/banker_safety_check_top.sv
// Top level of the banker's algorithm safety check block.
//
//  channel  direction  payload
//  s_axis   in         tuser: kind[1:0]; tdata: proc_index, res_index, amount
//  m_axis   out        tdata: proc_id, has_proc, safe; tlast: last of a run
//  cfg      in         cfg_index_i selects the register, cfg_data_i is the value
//
// For every unfinished process examined, a run beat reads and compares one
// resource at a time through the single read port of each table and then
// decides; finished processes are skipped. A new pass starts when the last
// one made progress and some process is still unfinished. Reset is
// asynchronous and needs no clearing pass. While a result waits on m_axis
// the scan stalls only when it has another result to hand over.
`timescale 1ns / 1ps

module banker_safety_check_top import bsc_pkg::*; #(
  parameter int unsigned MAX_PROCS     = DEF_MAX_PROCS,
  parameter int unsigned MAX_RESOURCES = DEF_MAX_RESOURCES,
  parameter int unsigned COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // proc_index[2:0], res_index[4:3], amount[12:5], zero[15:13]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // proc_id[2:0], has_proc[3], safe[4], zero[7:5]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  bsc_cmd_t             cmd;
  bsc_status_t          status;
  kind_e                in_kind;
  logic [PROC_ID_W-1:0] out_proc_id;
  logic                 out_has_proc, out_safe;

  assign in_kind     = kind_e'(s_axis_tuser);
  assign cfg_ready_o = 1'b1;

  bsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (in_kind),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsc_datapath #(
    .MAX_PROCS     (MAX_PROCS),
    .MAX_RESOURCES (MAX_RESOURCES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_kind_i      (in_kind),
    .in_proc_i      (s_axis_tdata[2:0]),
    .in_res_i       (s_axis_tdata[4:3]),
    .in_amount_i    (s_axis_tdata[12:5]),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_proc_id_o  (out_proc_id),
    .out_has_proc_o (out_has_proc),
    .out_safe_o     (out_safe),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_safe, out_has_proc, out_proc_id};

`ifndef SYNTHESIS
  // The controller issues at most one command per cycle.
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("controller issued overlapping commands");

  // Only a process whose need fitted is accepted.
  a_accept_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> status.fits)
    else $error("process accepted without fitting");

  // A result is never written over one that is still waiting.
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd.accept && status.has_pending) || cmd.finish) |-> status.out_free)
    else $error("result register overwritten");

  // A safe verdict always names a process.
  a_safe_has_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[4]) |-> (m_axis_tlast && m_axis_tdata[3]))
    else $error("safe result without a process");
`endif

endmodule

### dv/tb_banker_safety_check_top.sv
// Self-checking testbench for the banker's safety check block.
`timescale 1ns / 1ps

module tb_banker_safety_check_top;
  import bsc_pkg::*;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned SETTLE_CYCLES = 16;
  // Limit on a stretch without any handshake before the watchdog fails the test.
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned ITEM_GOAL     = 106;
  localparam int unsigned RESULT_GOAL   = 48;
  localparam int unsigned PAD_W         = IN_DATA_W - PROC_IDX_W - RES_IDX_W - AMOUNT_W;
  // Register index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // One entry of the safe sequence as it leaves the block.
  typedef struct packed {
    logic [PROC_ID_W-1:0] proc_id;
    logic                 has_proc;
    logic                 safe;
    logic                 is_last;
  } seq_step_t;

  // Keeps a copy of the tables and registers and predicts the safe sequence.
  class safety_seq_board;
    bit [AMOUNT_W-1:0]       alloc_tab [DEF_MAX_PROCS][DEF_MAX_RESOURCES];
    bit [AMOUNT_W-1:0]       max_tab   [DEF_MAX_PROCS][DEF_MAX_RESOURCES];
    bit [AMOUNT_W-1:0]       avail_vec [DEF_MAX_RESOURCES];
    int unsigned             work_vec  [DEF_MAX_RESOURCES];
    bit [DEF_MAX_PROCS-1:0]  finished;
    bit [PROCS_CFG_W-1:0]    procs_reg = PROCS_RESET;
    bit [RES_CFG_W-1:0]      res_reg   = RES_RESET;
    seq_step_t               expected_seq [$];
    int unsigned             mismatches;
    int unsigned             results_predicted;

    function int unsigned pending();
      return expected_seq.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_PROCS) begin
        procs_reg = val[PROCS_CFG_W-1:0];
      end else if (idx == CFG_RES) begin
        res_reg = val[RES_CFG_W-1:0];
      end
    endfunction

    // Walks the processes in index order until all finish or a pass stalls.
    function void predict_run();
      int unsigned np;
      int unsigned nr;
      int unsigned done;
      bit          progress;
      bit          fits;
      bit          have;
      seq_step_t   held;
      np = (procs_reg == 0) ? 1 : ((procs_reg > DEF_MAX_PROCS) ? DEF_MAX_PROCS : procs_reg);
      nr = (res_reg == 0) ? 1 : ((res_reg > DEF_MAX_RESOURCES) ? DEF_MAX_RESOURCES : res_reg);
      for (int r = 0; r < DEF_MAX_RESOURCES; r++) work_vec[r] = avail_vec[r];
      finished = '0;
      done     = 0;
      progress = 1'b1;
      have     = 1'b0;
      held     = '0;
      while (done < np && progress) begin
        progress = 1'b0;
        for (int p = 0; p < np; p++) begin
          if (!finished[p]) begin
            fits = 1'b1;
            for (int r = 0; r < nr; r++) begin
              if (max_tab[p][r] > work_vec[r] + alloc_tab[p][r]) fits = 1'b0;
            end
            if (fits) begin
              for (int r = 0; r < nr; r++) work_vec[r] += alloc_tab[p][r];
              finished[p] = 1'b1;
              done++;
              progress = 1'b1;
              // The previous entry is known not to be the last one now.
              if (have) begin
                expected_seq.push_back(held);
                results_predicted++;
              end
              held          = '0;
              held.proc_id  = PROC_ID_W'(p);
              held.has_proc = 1'b1;
              have          = 1'b1;
            end
          end
        end
      end
      // Nothing accepted still closes the run with one empty entry.
      if (have) held.safe = (done == np);
      held.is_last = 1'b1;
      expected_seq.push_back(held);
      results_predicted++;
    endfunction

    function void note_beat(kind_e kind, logic [PROC_IDX_W-1:0] pidx,
                            logic [RES_IDX_W-1:0] ridx, logic [AMOUNT_W-1:0] amt);
      case (kind)
        KIND_LOAD_ALLOC: alloc_tab[pidx][ridx] = amt;
        KIND_LOAD_MAX:   max_tab[pidx][ridx] = amt;
        KIND_LOAD_AVAIL: avail_vec[ridx] = amt;
        KIND_RUN:        predict_run();
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_beat(logic [OUT_DATA_W-1:0] data, logic last_bit);
      seq_step_t want;
      if (expected_seq.size() == 0) begin
        report($sformatf("unexpected result data=%h last=%b", data, last_bit));
        return;
      end
      want = expected_seq.pop_front();
      if (data[2:0] != want.proc_id)
        report($sformatf("proc_id %0d, expected %0d", data[2:0], want.proc_id));
      if (data[3] != want.has_proc)
        report($sformatf("has_proc %b, expected %b", data[3], want.has_proc));
      if (data[4] != want.safe)
        report($sformatf("safe %b, expected %b", data[4], want.safe));
      if (last_bit != want.is_last)
        report($sformatf("last %b, expected %b", last_bit, want.is_last));
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [KIND_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  safety_seq_board board;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     items_sent;
  int unsigned     quiet_cycles;
  int unsigned     cur_np = DEF_MAX_PROCS;
  int unsigned     cur_nr = DEF_MAX_RESOURCES;

  banker_safety_check_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Result side back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every handshake is observed here, so inputs are noted before results are checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        board.note_beat(kind_e'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[4:3],
                        s_axis_tdata[12:5]);
      end
      if (m_axis_tvalid && m_axis_tready) board.check_beat(m_axis_tdata, m_axis_tlast);
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  // Watchdog on a stalled run.
  initial begin : watchdog
    @(posedge clk_i);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("FAIL banker_safety_check_top");
    $finish;
  end

  task automatic set_idling(int unsigned mode);
    case (mode)
      1: begin
        send_idle_pct  = 67;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 67;
      end
      3: begin
        send_idle_pct  = 29;
        recv_stall_pct = 29;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Offers one beat, with a random gap ahead of it, and waits until it is taken.
  task automatic send_beat(kind_e kind, logic [PROC_IDX_W-1:0] pidx,
                           logic [RES_IDX_W-1:0] ridx, logic [AMOUNT_W-1:0] amt);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{PAD_W{1'b0}}, amt, ridx, pidx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // The caller lowers cfg_valid_i after the last write of a group.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Holds the sender until every predicted entry has come back, then lets the block settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly small process and resource counts, sometimes the extremes and out-of-range values.
  task automatic pick_config();
    logic [CFG_DATA_W-1:0] pv;
    logic [CFG_DATA_W-1:0] rv;
    case ($urandom_range(9))
      0:       pv = 4'd0;
      1:       pv = 4'd15;
      2:       pv = 4'(DEF_MAX_PROCS);
      default: pv = 4'($urandom_range(1, 4));
    endcase
    case ($urandom_range(9))
      0:       rv = 4'd0;
      1:       rv = 4'($urandom_range(5, 7));
      2:       rv = 4'(DEF_MAX_RESOURCES);
      default: rv = 4'($urandom_range(1, 2));
    endcase
    // Bit 3 is not part of the resource register.
    rv[3] = 1'($urandom_range(1));
    write_reg(CFG_PROCS, pv);
    write_reg(CFG_RES, rv);
    cfg_valid_i <= 1'b0;
    cur_np = (pv == 0) ? 1 : ((pv > DEF_MAX_PROCS) ? DEF_MAX_PROCS : pv);
    cur_nr = (rv[2:0] == 0) ? 1 : ((rv[2:0] > DEF_MAX_RESOURCES) ? DEF_MAX_RESOURCES : rv[2:0]);
  endtask

  // Table updates aimed at the entries in use, with some noise outside them.
  task automatic random_loads(int unsigned count);
    kind_e                 kind;
    logic [PROC_IDX_W-1:0] pidx;
    logic [RES_IDX_W-1:0]  ridx;
    logic [AMOUNT_W-1:0]   amt;
    repeat (count) begin
      kind = kind_e'($urandom_range(2));
      pidx = ($urandom_range(7) == 0) ? PROC_IDX_W'($urandom_range(7))
                                      : PROC_IDX_W'($urandom_range(cur_np - 1));
      ridx = ($urandom_range(7) == 0) ? RES_IDX_W'($urandom_range(3))
                                      : RES_IDX_W'($urandom_range(cur_nr - 1));
      if ($urandom_range(5) == 0) begin
        amt = AMOUNT_W'($urandom_range(255));
      end else begin
        case (kind)
          KIND_LOAD_ALLOC: amt = AMOUNT_W'($urandom_range(12));
          KIND_LOAD_MAX:   amt = AMOUNT_W'($urandom_range(30));
          default:         amt = AMOUNT_W'($urandom_range(24));
        endcase
      end
      send_beat(kind, pidx, ridx, amt);
    end
  endtask

  initial begin
    int unsigned scen;
    board = new();
    set_idling(0);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty tables: every process fits at once, safe in index order.
    send_beat(KIND_RUN, 3'd0, 2'd0, 8'd0);
    // The last process can never fit: unsafe after seven accepted.
    send_beat(KIND_LOAD_MAX, 3'd7, 2'd3, 8'd255);
    send_beat(KIND_RUN, 3'd7, 2'd3, 8'd255);
    // Available load ignores the process index; the state turns safe again.
    send_beat(KIND_LOAD_AVAIL, 3'd7, 2'd3, 8'd255);
    send_beat(KIND_RUN, 3'd0, 2'd0, 8'd0);
    // Allocation above maximum gives a negative need.
    send_beat(KIND_LOAD_ALLOC, 3'd0, 2'd0, 8'd255);
    send_beat(KIND_RUN, 3'd0, 2'd0, 8'd0);

    // Zero in both registers counts as one process and one resource.
    wait_drained();
    write_reg(CFG_PROCS, 4'd0);
    write_reg(CFG_RES, 4'd0);
    cfg_valid_i <= 1'b0;
    send_beat(KIND_LOAD_MAX, 3'd0, 2'd0, 8'd200);
    send_beat(KIND_RUN, 3'd0, 2'd0, 8'd0);
    // Nothing fits: a single empty closing entry.
    send_beat(KIND_LOAD_ALLOC, 3'd0, 2'd0, 8'd0);
    send_beat(KIND_RUN, 3'd0, 2'd0, 8'd0);

    // Values above the maximum saturate; the spare index is written too.
    wait_drained();
    write_reg(CFG_PROCS, 4'd15);
    write_reg(CFG_RES, 4'd7);
    write_reg(CFG_SPARE, 4'd15);
    cfg_valid_i <= 1'b0;
    // Process 0 only fits on the second pass, after process 5 returns its units.
    send_beat(KIND_LOAD_ALLOC, 3'd5, 2'd0, 8'd200);
    send_beat(KIND_RUN, 3'd0, 2'd0, 8'd0);
    send_beat(KIND_LOAD_AVAIL, 3'd0, 2'd1, 8'd0);
    send_beat(KIND_LOAD_MAX, 3'd2, 2'd1, 8'd1);
    send_beat(KIND_RUN, 3'd0, 2'd0, 8'd0);

    // Random phase: table updates followed by a check, several settings and idle mixes.
    scen = 0;
    while (items_sent < ITEM_GOAL || board.results_predicted < RESULT_GOAL) begin
      if (scen % 3 == 0) begin
        wait_drained();
        pick_config();
      end
      set_idling(scen % 4);
      random_loads($urandom_range(2, 8));
      send_beat(KIND_RUN, PROC_IDX_W'($urandom_range(7)), RES_IDX_W'($urandom_range(3)),
                AMOUNT_W'($urandom_range(255)));
      scen++;
    end

    wait_drained();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS banker_safety_check_top");
    end else begin
      $display("FAIL banker_safety_check_top");
    end
    $finish;
  end

endmodule
